[hw/rtl/ucd_pkg.sv]
package ucd_pkg;

  localparam int unsigned CpWidth = 31;
  localparam int unsigned TotalWidth = 32;

  localparam logic [CpWidth-1:0] ReplacementCp = 31'h0000_FFFD;
  localparam logic [CpWidth-1:0] WatchedReset = 31'h0000_202F;

  // Bit n set means code point 0x80 + n has a named entity.
  localparam logic [31:0] CtrlEntityMask = 32'hDFFE_5FFD;

  typedef enum logic [1:0] {
    KIND_ASCII   = 2'd0,
    KIND_ENTITY  = 2'd1,
    KIND_NUMERIC = 2'd2,
    KIND_REPLACE = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } ucd_in_t;

  typedef struct packed {
    logic [CpWidth-1:0]    code_point;
    kind_e                 kind;
    logic                  has_entity;
    logic                  is_watched;
    logic [TotalWidth-1:0] error_total;
    logic [TotalWidth-1:0] watched_total;
    logic                  last;
  } ucd_out_t;

  typedef struct packed {
    logic first;
    logic second;
  } ucd_push_t;

endpackage

[hw/rtl/ucd_out_fifo.sv]
module ucd_out_fifo import ucd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ucd_push_t push_i,
  input  ucd_out_t  data0_i,
  input  ucd_out_t  data1_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ucd_out_t  out_data_o
);

  ucd_out_t   mem_q [3];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  function automatic logic [1:0] ptr_next(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign room_o      = (count_q < 2'd2);
  assign pop         = out_valid_o & out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_i.second) begin
      wr_ptr_d = ptr_next(ptr_next(wr_ptr_q));
    end else if (push_i.first) begin
      wr_ptr_d = ptr_next(wr_ptr_q);
    end
    rd_ptr_d = pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i.first} + {1'b0, push_i.second} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wr_ptr_q] <= data0_i;
    end
    if (push_i.second) begin
      mem_q[ptr_next(wr_ptr_q)] <= data1_i;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3 || (push_i.first == 1'b0 && push_i.second == 1'b0))
    else $error("result buffer written while full");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.first || push_i.second) |-> count_q <= 2'd1)
    else $error("results pushed without room for two");
  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.second |-> push_i.first)
    else $error("second result pushed without a first");
`endif

endmodule

[hw/rtl/utf8_stream_decoder_top.sv]
// Latency: a request's results are buffered on acceptance, readable from the next cycle.
// Throughput: one request per cycle while the buffer has room; a request causes zero, one
// or two results; the three-entry buffer drains one per cycle while out_ready_i is high.
// Reset: rst_ni clears the decode state, both counters and the result buffer, and loads
// the watched code point with 0x202F. No clearing pass is needed.
module utf8_stream_decoder_top import ucd_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ucd_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ucd_out_t           out_data_o,
  input  logic               cfg_we_i,
  input  logic [CpWidth-1:0] cfg_data_i
);

  typedef logic [COUNTER_WIDTH-1:0] cnt_t;

  logic [CpWidth-1:0] watched_q;
  logic [CpWidth-1:0] partial_q, partial_d;
  logic [2:0]         remain_q, remain_d;
  logic [2:0]         len_q, len_d;
  cnt_t               err_q, err_d;
  cnt_t               wat_q, wat_d;

  logic               accept;
  logic               room;
  logic [7:0]         b;
  logic               pending;
  logic               s_code, s_err, s_lead;
  logic [2:0]         s_len;
  logic [CpWidth-1:0] s_val;
  logic [CpWidth-1:0] pv;
  logic               r0_v, r0_err, r1_v, r1_err;
  logic [CpWidth-1:0] r0_cp, r1_cp;
  logic               r0_wat, r1_wat;
  cnt_t               e1, w1, e2, w2;
  ucd_out_t           res0, res1;
  ucd_push_t          push;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic overlong(input logic [2:0] len, input logic [CpWidth-1:0] v);
    logic res;
    case (len)
      3'd2:    res = (v < 31'h0000_0080);
      3'd3:    res = (v < 31'h0000_0800);
      3'd4:    res = (v < 31'h0001_0000);
      3'd5:    res = (v < 31'h0020_0000);
      default: res = (v < 31'h0400_0000);
    endcase
    return res;
  endfunction

  function automatic ucd_out_t make_res(input logic err, input logic [CpWidth-1:0] cp,
                                        input logic wat, input cnt_t e, input cnt_t w,
                                        input logic last);
    ucd_out_t r;
    r.code_point    = err ? ReplacementCp : cp;
    r.is_watched    = ~err & wat;
    r.has_entity    = 1'b0;
    r.error_total   = TotalWidth'(e);
    r.watched_total = TotalWidth'(w);
    r.last          = last;
    if (err) begin
      r.kind = KIND_REPLACE;
    end else if (cp[CpWidth-1:7] == '0) begin
      r.kind = KIND_ASCII;
    end else if (cp[CpWidth-1:9] == '0) begin
      r.kind       = KIND_ENTITY;
      r.has_entity = (cp == 31'h0000_0178) || (cp[CpWidth-1:5] >= 26'd5)
                     || ((cp[CpWidth-1:5] == 26'd4) && CtrlEntityMask[cp[4:0]]);
      r.has_entity = r.has_entity && (cp[CpWidth-1:8] == '0 || cp == 31'h0000_0178);
    end else begin
      r.kind = KIND_NUMERIC;
    end
    return r;
  endfunction

  assign accept     = in_valid_i & in_ready_o;
  assign in_ready_o = room;
  assign b          = in_data_i.data_byte;
  assign pending    = (remain_q != 3'd0);
  assign pv         = {partial_q[CpWidth-7:0], b[5:0]};

  always_comb begin
    s_code = 1'b0;
    s_err  = 1'b0;
    s_lead = 1'b1;
    s_len  = 3'd0;
    s_val  = '0;
    if (!b[7]) begin
      s_code = 1'b1;
      s_lead = 1'b0;
    end else if (b[7:5] == 3'b110) begin
      s_len = 3'd2;
      s_val = {26'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      s_len = 3'd3;
      s_val = {27'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      s_len = 3'd4;
      s_val = {28'd0, b[2:0]};
    end else if (b[7:2] == 6'b111110) begin
      s_len = 3'd5;
      s_val = {29'd0, b[1:0]};
    end else if (b[7:1] == 7'b1111110) begin
      s_len = 3'd6;
      s_val = {30'd0, b[0]};
    end else begin
      s_err  = 1'b1;
      s_lead = 1'b0;
    end
  end

  always_comb begin
    partial_d = partial_q;
    remain_d  = remain_q;
    len_d     = len_q;
    r0_v      = 1'b0;
    r0_err    = 1'b0;
    r0_cp     = {23'd0, b};
    r1_v      = 1'b0;
    r1_err    = s_err;
    r1_cp     = {23'd0, b};
    if (in_data_i.end_of_stream) begin
      if (pending) begin
        r0_v      = 1'b1;
        r0_err    = 1'b1;
        partial_d = '0;
        remain_d  = 3'd0;
        len_d     = 3'd0;
      end
    end else if (!pending) begin
      r0_v   = s_code | s_err;
      r0_err = s_err;
      if (s_lead) begin
        partial_d = s_val;
        remain_d  = s_len - 3'd1;
        len_d     = s_len;
      end
    end else if (b[7:6] != 2'b10) begin
      r0_v      = 1'b1;
      r0_err    = 1'b1;
      r1_v      = s_code | s_err;
      partial_d = s_lead ? s_val : '0;
      remain_d  = s_lead ? s_len - 3'd1 : 3'd0;
      len_d     = s_lead ? s_len : 3'd0;
    end else if (remain_q == 3'd1) begin
      r0_v      = 1'b1;
      r0_err    = overlong(len_q, pv);
      r0_cp     = pv;
      partial_d = '0;
      remain_d  = 3'd0;
      len_d     = 3'd0;
    end else begin
      partial_d = pv;
      remain_d  = remain_q - 3'd1;
    end
  end

  always_comb begin
    r0_wat = (r0_cp == watched_q);
    r1_wat = (r1_cp == watched_q);
    e1     = (r0_v && r0_err) ? sat_inc(err_q) : err_q;
    w1     = (r0_v && !r0_err && r0_wat) ? sat_inc(wat_q) : wat_q;
    e2     = (r1_v && r1_err) ? sat_inc(e1) : e1;
    w2     = (r1_v && !r1_err && r1_wat) ? sat_inc(w1) : w1;
    err_d  = e2;
    wat_d  = w2;
    res0   = make_res(r0_err, r0_cp, r0_wat, e1, w1, ~r1_v);
    res1   = make_res(r1_err, r1_cp, r1_wat, e2, w2, 1'b1);
    push.first  = accept & r0_v;
    push.second = accept & r1_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watched_q <= WatchedReset;
      partial_q <= '0;
      remain_q  <= 3'd0;
      len_q     <= 3'd0;
      err_q     <= '0;
      wat_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        watched_q <= cfg_data_i;
      end
      if (accept) begin
        partial_q <= partial_d;
        remain_q  <= remain_d;
        len_q     <= len_d;
        err_q     <= err_d;
        wat_q     <= wat_d;
      end
    end
  end

  ucd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data0_i     (res0),
    .data1_i     (res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    remain_q == 3'd0 |-> (partial_q == '0 && len_q == 3'd0))
    else $error("idle decoder holds a partial sequence");
  a_remain_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    remain_q != 3'd0 |-> (remain_q < len_q && len_q >= 3'd2 && len_q <= 3'd6))
    else $error("bytes still due do not fit the sequence length");
  a_err_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> (err_q == $past(err_q) && wat_q == $past(wat_q)))
    else $error("counter changed without an accepted request");
`endif

endmodule
